### design/pllm_pkg.sv
`default_nettype none

package pllm_pkg;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_TAKE,
    S_WALK_INS,
    S_WALK_DEL,
    S_RELEASE
  } state_t;

  typedef logic [1:0] req_t;
  localparam req_t REQ_INS_FRONT = 2'd0;
  localparam req_t REQ_INS_BACK  = 2'd1;
  localparam req_t REQ_DEL_FIRST = 2'd2;
  localparam req_t REQ_DEL_LAST  = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STAT_DONE  = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

  localparam int VALUE_W = 32;

endpackage

`default_nettype wire

### design/pllm_link_ram.sv
`default_nettype none

// Link memory: one write port, one registered read port.
// After reset it sweeps entry i <- i-1 (entry 0 <- null), one entry a cycle.
module pllm_link_ram #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 we,
  input  wire logic [$clog2(POOL_DEPTH)-1:0]        waddr,
  input  wire logic [$clog2(POOL_DEPTH+1)-1:0]      wdata,
  input  wire logic                                 re,
  input  wire logic [$clog2(POOL_DEPTH)-1:0]        raddr,
  output logic      [$clog2(POOL_DEPTH+1)-1:0]      rdata,
  output logic                                      ready
);

  localparam int SLOT_W = $clog2(POOL_DEPTH);
  localparam int LINK_W = $clog2(POOL_DEPTH + 1);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_DEPTH);

  logic [LINK_W-1:0] mem [POOL_DEPTH];
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic              mwe;
  logic [SLOT_W-1:0] mwaddr;
  logic [LINK_W-1:0] mwdata;

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (!done_r) begin
      cnt_nxt = cnt_r + SLOT_W'(1);
      if (cnt_r == SLOT_W'(POOL_DEPTH - 1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    if (!done_r) begin
      mwe    = 1'b1;
      mwaddr = cnt_r;
      mwdata = (cnt_r == '0) ? NIL : LINK_W'(cnt_r - SLOT_W'(1));
    end else begin
      mwe    = we;
      mwaddr = waddr;
      mwdata = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) begin
      mem[mwaddr] <= mwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign ready = done_r;

endmodule

`default_nettype wire

### design/pool_linked_list_manager.sv
`default_nettype none

// Results: errors (pool full, list empty) are answered from the idle state, front
// insert from the take state and front delete from the release state; back
// insert into a non-empty list and back delete first walk one link per cycle
// through the link memory read port. One request at a time; busy drops in the cycle out_valid shows.
// Reset: synchronous, active low; then a sweep of the link memory, with busy high
// until it is done. Results cannot be stalled by the receiver.
module pool_linked_list_manager #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         in_req_type,
  input  wire logic signed [31:0]                 in_value,
  output logic                                    out_valid,
  output logic [1:0]                              out_status,
  output logic [$clog2(POOL_DEPTH)-1:0]           out_slot,
  output logic signed [31:0]                      out_removed_value,
  output logic [$clog2(POOL_DEPTH+1)-1:0]         out_list_head
);

  localparam int SLOT_W = $clog2(POOL_DEPTH);
  localparam int LINK_W = $clog2(POOL_DEPTH + 1);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_DEPTH);

  function automatic logic is_slot(input logic [LINK_W-1:0] l);
    return l < NIL;
  endfunction

  function automatic logic [LINK_W-1:0] norm_link(input logic [LINK_W-1:0] l);
    return (l < NIL) ? l : NIL;
  endfunction

  pllm_pkg::state_t state_r, state_nxt;
  pllm_pkg::req_t   req_r, req_nxt;
  logic [LINK_W-1:0] free_r, free_nxt;
  logic [LINK_W-1:0] first_r, first_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic [LINK_W-1:0] prev_r, prev_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic                         out_valid_r, out_valid_nxt;
  pllm_pkg::status_t            out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]            out_slot_r, out_slot_nxt;
  logic [pllm_pkg::VALUE_W-1:0] out_rem_r, out_rem_nxt;
  logic [LINK_W-1:0]            out_head_r, out_head_nxt;

  // link memory port
  logic              lwe, lre, ram_ready;
  logic [SLOT_W-1:0] lwaddr, lraddr;
  logic [LINK_W-1:0] lwdata, lrdata, lnext;

  // value memory
  logic [pllm_pkg::VALUE_W-1:0] value_mem [POOL_DEPTH];
  logic                         vwe, vre;
  logic [SLOT_W-1:0]            vwaddr, vraddr;
  logic [pllm_pkg::VALUE_W-1:0] vwdata, vrdata;

  logic accept, req_ins;

  assign accept  = start && (state_r == pllm_pkg::S_IDLE);
  assign req_ins = in_req_type inside {pllm_pkg::REQ_INS_FRONT, pllm_pkg::REQ_INS_BACK};
  assign lnext   = norm_link(lrdata);

  pllm_link_ram #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (lwe),
    .waddr (lwaddr),
    .wdata (lwdata),
    .re    (lre),
    .raddr (lraddr),
    .rdata (lrdata),
    .ready (ram_ready)
  );

  always_ff @(posedge clk) begin
    if (vwe) begin
      value_mem[vwaddr] <= vwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (vre) begin
      vrdata <= value_mem[vraddr];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pllm_pkg::S_INIT: begin
        if (ram_ready) state_nxt = pllm_pkg::S_IDLE;
      end
      pllm_pkg::S_IDLE: begin
        if (start) begin
          if (req_ins) begin
            if (is_slot(free_r)) state_nxt = pllm_pkg::S_TAKE;
          end else if (is_slot(first_r)) begin
            state_nxt = (in_req_type == pllm_pkg::REQ_DEL_FIRST) ?
                        pllm_pkg::S_RELEASE : pllm_pkg::S_WALK_DEL;
          end
        end
      end
      pllm_pkg::S_TAKE: begin
        if (req_r == pllm_pkg::REQ_INS_BACK && is_slot(first_r)) begin
          state_nxt = pllm_pkg::S_WALK_INS;
        end else begin
          state_nxt = pllm_pkg::S_IDLE;
        end
      end
      pllm_pkg::S_WALK_INS: begin
        if (!is_slot(lnext)) state_nxt = pllm_pkg::S_IDLE;
      end
      pllm_pkg::S_WALK_DEL: begin
        if (!is_slot(lnext)) state_nxt = pllm_pkg::S_RELEASE;
      end
      pllm_pkg::S_RELEASE: state_nxt = pllm_pkg::S_IDLE;
      default: state_nxt = pllm_pkg::S_INIT;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    req_nxt   = req_r;
    free_nxt  = free_r;
    first_nxt = first_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    slot_nxt  = slot_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_rem_nxt    = out_rem_r;
    out_head_nxt   = out_head_r;

    lwe    = 1'b0;
    lwaddr = cur_r[SLOT_W-1:0];
    lwdata = NIL;
    lre    = 1'b0;
    lraddr = first_r[SLOT_W-1:0];
    vwe    = 1'b0;
    vwaddr = free_r[SLOT_W-1:0];
    vwdata = $unsigned(in_value);
    vre    = 1'b0;
    vraddr = cur_r[SLOT_W-1:0];

    case (state_r)
      pllm_pkg::S_IDLE: begin
        if (start) begin
          req_nxt = in_req_type;
          if (req_ins) begin
            if (!is_slot(free_r)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = pllm_pkg::STAT_FULL;
              out_slot_nxt   = '0;
              out_rem_nxt    = '0;
              out_head_nxt   = first_r;
            end else begin
              slot_nxt = free_r[SLOT_W-1:0];
              lre      = 1'b1;
              lraddr   = free_r[SLOT_W-1:0];
              vwe      = 1'b1;
            end
          end else if (!is_slot(first_r)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pllm_pkg::STAT_EMPTY;
            out_slot_nxt   = '0;
            out_rem_nxt    = '0;
            out_head_nxt   = first_r;
          end else begin
            cur_nxt  = first_r;
            prev_nxt = NIL;
            lre      = 1'b1;
            lraddr   = first_r[SLOT_W-1:0];
            if (in_req_type == pllm_pkg::REQ_DEL_FIRST) begin
              vre    = 1'b1;
              vraddr = first_r[SLOT_W-1:0];
            end
          end
        end
      end
      pllm_pkg::S_TAKE: begin
        free_nxt = lnext;
        lwe      = 1'b1;
        lwaddr   = slot_r;
        lwdata   = (req_r == pllm_pkg::REQ_INS_FRONT) ? first_r : NIL;
        if (req_r == pllm_pkg::REQ_INS_BACK && is_slot(first_r)) begin
          cur_nxt = first_r;
          lre     = 1'b1;
          lraddr  = first_r[SLOT_W-1:0];
        end else begin
          first_nxt      = LINK_W'(slot_r);
          out_valid_nxt  = 1'b1;
          out_status_nxt = pllm_pkg::STAT_DONE;
          out_slot_nxt   = slot_r;
          out_rem_nxt    = '0;
          out_head_nxt   = LINK_W'(slot_r);
        end
      end
      pllm_pkg::S_WALK_INS: begin
        if (is_slot(lnext)) begin
          cur_nxt = lnext;
          lre     = 1'b1;
          lraddr  = lnext[SLOT_W-1:0];
        end else begin
          // tail found: hook the new slot behind it
          lwe            = 1'b1;
          lwaddr         = cur_r[SLOT_W-1:0];
          lwdata         = LINK_W'(slot_r);
          out_valid_nxt  = 1'b1;
          out_status_nxt = pllm_pkg::STAT_DONE;
          out_slot_nxt   = slot_r;
          out_rem_nxt    = '0;
          out_head_nxt   = first_r;
        end
      end
      pllm_pkg::S_WALK_DEL: begin
        if (is_slot(lnext)) begin
          prev_nxt = cur_r;
          cur_nxt  = lnext;
          lre      = 1'b1;
          lraddr   = lnext[SLOT_W-1:0];
        end else begin
          vre    = 1'b1;
          vraddr = cur_r[SLOT_W-1:0];
          if (is_slot(prev_r)) begin
            lwe    = 1'b1;
            lwaddr = prev_r[SLOT_W-1:0];
            lwdata = NIL;
          end else begin
            first_nxt = NIL;
          end
        end
      end
      pllm_pkg::S_RELEASE: begin
        if (req_r == pllm_pkg::REQ_DEL_FIRST) begin
          first_nxt = lnext;
        end
        // freed slot goes to the head of the free chain
        lwe            = 1'b1;
        lwaddr         = cur_r[SLOT_W-1:0];
        lwdata         = free_r;
        free_nxt       = cur_r;
        out_valid_nxt  = 1'b1;
        out_status_nxt = pllm_pkg::STAT_DONE;
        out_slot_nxt   = cur_r[SLOT_W-1:0];
        out_rem_nxt    = vrdata;
        out_head_nxt   = first_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pllm_pkg::S_INIT;
      free_r      <= LINK_W'(POOL_DEPTH - 1);
      first_r     <= NIL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    slot_r       <= slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_rem_r    <= out_rem_nxt;
    out_head_r   <= out_head_nxt;
  end

  assign busy              = (state_r != pllm_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_removed_value = $signed(out_rem_r);
  assign out_list_head     = out_head_r;

  a_no_link_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (lwe && lre) |-> (lwaddr != lraddr))
    else $error("link memory read and write hit the same entry");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid || busy))
    else $error("accepted request neither answered nor in progress");

  a_head_not_free: assert property (@(posedge clk) disable iff (!rst_n)
    (is_slot(first_r) && is_slot(free_r)) |-> (first_r != free_r))
    else $error("list head is also the free chain head");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a request is still in progress");

endmodule

`default_nettype wire

### test/tb_pool_linked_list_manager.sv
`timescale 1ns / 1ps

module tb_pool_linked_list_manager;

  localparam int POOL_DEPTH = 16;
  localparam logic [4:0] NULL_SLOT = 5'd16;
  localparam int ITEM_COUNT = 1550;

  typedef struct {
    pllm_pkg::req_t req;
    logic signed [31:0] value;
    int unsigned gap;
  } list_req_t;

  typedef struct {
    pllm_pkg::status_t status;
    logic [3:0] slot;
    logic signed [31:0] removed;
    logic [4:0] head;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_req_type = '0;
  logic signed [31:0] in_value = '0;
  logic busy;
  logic out_valid;
  logic [1:0] out_status;
  logic [3:0] out_slot;
  logic signed [31:0] out_removed_value;
  logic [4:0] out_list_head;

  list_req_t pending_reqs[$];
  list_result_t awaited_results[$];
  int unsigned idle_left = 0;
  int unsigned mismatch_count = 0;

  // shadow copy of the pool
  logic [4:0] link_ram[POOL_DEPTH];
  logic signed [31:0] data_ram[POOL_DEPTH];
  logic [4:0] free_top;
  logic [4:0] list_first;

  pool_linked_list_manager #(.POOL_DEPTH(POOL_DEPTH)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_slot(out_slot),
    .out_removed_value(out_removed_value),
    .out_list_head(out_list_head)
  );

  always #2 clk = ~clk;

  // out-of-range links count as the end of a chain
  function automatic logic [4:0] link_of(input logic [4:0] s);
    if (s >= NULL_SLOT) return NULL_SLOT;
    return (link_ram[s] < NULL_SLOT) ? link_ram[s] : NULL_SLOT;
  endfunction

  task automatic return_to_free(input logic [4:0] s);
    link_ram[s] = free_top;
    free_top = s;
  endtask

  task automatic pool_apply(input pllm_pkg::req_t req, input logic signed [31:0] val,
                            output list_result_t res);
    logic [4:0] s;
    logic [4:0] prev;
    logic [4:0] cur;
    logic [4:0] nxt;
    int steps;
    res.status = pllm_pkg::STAT_DONE;
    res.slot = '0;
    res.removed = '0;
    if (list_first >= NULL_SLOT) list_first = NULL_SLOT;
    if (req == pllm_pkg::REQ_INS_FRONT || req == pllm_pkg::REQ_INS_BACK) begin
      s = free_top;
      if (s >= NULL_SLOT) begin
        res.status = pllm_pkg::STAT_FULL;
      end else begin
        free_top = link_of(s);
        data_ram[s] = val;
        res.slot = s[3:0];
        if (req == pllm_pkg::REQ_INS_FRONT) begin
          link_ram[s] = list_first;
          list_first = s;
        end else begin
          link_ram[s] = NULL_SLOT;
          if (list_first >= NULL_SLOT) begin
            list_first = s;
          end else begin
            cur = list_first;
            steps = 0;
            nxt = link_of(cur);
            while (nxt < NULL_SLOT && steps < POOL_DEPTH) begin
              cur = nxt;
              nxt = link_of(cur);
              steps++;
            end
            link_ram[cur] = s;
          end
        end
      end
    end else if (list_first >= NULL_SLOT) begin
      res.status = pllm_pkg::STAT_EMPTY;
    end else if (req == pllm_pkg::REQ_DEL_FIRST) begin
      s = list_first;
      list_first = link_of(s);
      res.slot = s[3:0];
      res.removed = data_ram[s];
      return_to_free(s);
    end else begin
      prev = NULL_SLOT;
      cur = list_first;
      steps = 0;
      nxt = link_of(cur);
      while (nxt < NULL_SLOT && steps < POOL_DEPTH) begin
        prev = cur;
        cur = nxt;
        nxt = link_of(cur);
        steps++;
      end
      if (prev < NULL_SLOT) link_ram[prev] = NULL_SLOT;
      else list_first = NULL_SLOT;
      res.slot = cur[3:0];
      res.removed = data_ram[cur];
      return_to_free(cur);
    end
    res.head = list_first;
  endtask

  task automatic queue_req(input pllm_pkg::req_t req, input logic signed [31:0] val,
                           input int unsigned gap);
    list_req_t r;
    r.req = req;
    r.value = val;
    r.gap = gap;
    pending_reqs.push_back(r);
  endtask

  // driver: start stays up across back-to-back transfers
  always @(posedge clk) begin
    list_result_t res;
    if (!rst_n) begin
      start <= 1'b0;
      idle_left <= 0;
    end else if (start && !busy) begin
      pool_apply(pending_reqs[0].req, pending_reqs[0].value, res);
      awaited_results.push_back(res);
      void'(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && pending_reqs[0].gap == 0) begin
        in_req_type <= pending_reqs[0].req;
        in_value <= pending_reqs[0].value;
      end else begin
        start <= 1'b0;
        idle_left <= (pending_reqs.size() > 0) ? pending_reqs[0].gap - 1 : 0;
      end
    end else if (!start) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
      end else if (pending_reqs.size() > 0) begin
        in_req_type <= pending_reqs[0].req;
        in_value <= pending_reqs[0].value;
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result status=%0d slot=%0d removed=%0d head=%0d",
                 $time, out_status, out_slot, out_removed_value, out_list_head);
      end else begin
        exp_res = awaited_results.pop_front();
        if (out_status !== exp_res.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, out_status);
        end
        if (out_slot !== exp_res.slot) begin
          mismatch_count++;
          $display("%0t: slot expected %0d actual %0d", $time, exp_res.slot, out_slot);
        end
        if (out_removed_value !== exp_res.removed) begin
          mismatch_count++;
          $display("%0t: removed_value expected %0d actual %0d", $time, exp_res.removed,
                   out_removed_value);
        end
        if (out_list_head !== exp_res.head) begin
          mismatch_count++;
          $display("%0t: list_head expected %0d actual %0d", $time, exp_res.head,
                   out_list_head);
        end
      end
    end
  end

  initial begin
    int added;
    int run_len;
    int ins_pct;
    bit no_idle;
    pllm_pkg::req_t req;
    logic signed [31:0] val;
    int unsigned gap;

    for (int i = 0; i < POOL_DEPTH; i++) begin
      link_ram[i] = (i == 0) ? NULL_SLOT : 5'(i - 1);
      data_ram[i] = '0;
    end
    free_top = 5'(POOL_DEPTH - 1);
    list_first = NULL_SLOT;

    // directed: deletes on an empty list, extreme values, removals from both ends of a
    // short list, then fill the pool and try both inserts against it
    queue_req(pllm_pkg::REQ_DEL_FIRST, 32'sd0, 0);
    queue_req(pllm_pkg::REQ_DEL_LAST, -32'sd1, 3);
    queue_req(pllm_pkg::REQ_INS_FRONT, 32'sh7fffffff, 0);
    queue_req(pllm_pkg::REQ_INS_BACK, 32'sh80000000, 0);
    queue_req(pllm_pkg::REQ_INS_FRONT, -32'sd1, 1);
    queue_req(pllm_pkg::REQ_INS_BACK, 32'sd0, 0);
    queue_req(pllm_pkg::REQ_DEL_LAST, 32'sh5a5a5a5a, 0);
    queue_req(pllm_pkg::REQ_DEL_FIRST, 32'sh25a5a5a5, 2);
    for (int i = 0; i < 14; i++)
      queue_req((i % 2) ? pllm_pkg::REQ_INS_BACK : pllm_pkg::REQ_INS_FRONT, $urandom, i % 3);
    queue_req(pllm_pkg::REQ_INS_FRONT, 32'sh7fffffff, 0);
    queue_req(pllm_pkg::REQ_INS_BACK, 32'sh80000000, 0);

    // random runs with varying insert bias so the list swings between empty and full
    added = 0;
    while (added < ITEM_COUNT) begin
      run_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: ins_pct = 15;
        1: ins_pct = 50;
        default: ins_pct = 85;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 99) < ins_pct)
          req = ($urandom_range(0, 1) == 0) ? pllm_pkg::REQ_INS_FRONT : pllm_pkg::REQ_INS_BACK;
        else
          req = ($urandom_range(0, 1) == 0) ? pllm_pkg::REQ_DEL_FIRST : pllm_pkg::REQ_DEL_LAST;
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0: val = 32'sd0;
            1: val = -32'sd1;
            2: val = 32'sh7fffffff;
            default: val = 32'sh80000000;
          endcase
        end else begin
          val = $urandom;
        end
        gap = no_idle ? 0 : $urandom_range(0, 11);
        queue_req(req, val, gap);
      end
      added += run_len;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || awaited_results.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
design/pllm_pkg.sv
design/pllm_link_ram.sv
design/pool_linked_list_manager.sv
test/tb_pool_linked_list_manager.sv
